[hdl/mlfqs_pkg.sv]
// Package with shared constants, types and helpers for the scheduler math block.
package mlfqs_pkg;

  localparam int THREADS_DEF       = 64;
  localparam int PRIORITY_MAX_DEF  = 63;
  localparam int FRACTION_BITS_DEF = 14;
  localparam int LOAD_OUT_MAX      = 8191;
  localparam int TABLE_W           = 32;
  localparam int NICE_W            = 6;

  localparam logic [2:0] FUNC_CLEAR    = 3'd0;
  localparam logic [2:0] FUNC_TICK     = 3'd1;
  localparam logic [2:0] FUNC_LOAD     = 3'd2;
  localparam logic [2:0] FUNC_DECAY    = 3'd3;
  localparam logic [2:0] FUNC_SET_NICE = 3'd4;
  localparam logic [2:0] FUNC_PRIORITY = 3'd5;

  typedef struct packed {
    logic start;
    logic is_div;
  } unit_ctl_t;

  function automatic logic [31:0] sat32(input logic signed [47:0] v);
    logic [31:0] r;
    if (v > 48'sh0000_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -48'sh0000_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/mlfqs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mlfqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/mlfqs_serial_unit.sv]
// Bit-serial unsigned multiplier (32x32) and restoring divider (64/32).
module mlfqs_serial_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlfqs_pkg::unit_ctl_t ctl_i,
  input  logic [63:0]          a_i,
  input  logic [31:0]          b_i,
  output logic                 done_o,
  output logic [63:0]          res_o
);

  import mlfqs_pkg::*;

  logic        busy_r;
  logic        div_r;
  logic        done_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r;
  logic [32:0] rem_r;
  logic [31:0] b_r;

  logic [32:0] mul_sum;
  logic [32:0] rem_sh;
  logic        ge;
  logic        last;

  always_comb begin
    mul_sum = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, b_r} : 33'd0);
    rem_sh  = {rem_r[31:0], acc_r[63]};
    ge      = rem_sh >= {1'b0, b_r};
    last    = div_r ? (cnt_r == 6'd63) : (cnt_r == 6'd31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      div_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (ctl_i.start) begin
        busy_r <= 1'b1;
        div_r  <= ctl_i.is_div;
        cnt_r  <= '0;
        acc_r  <= ctl_i.is_div ? a_i : {32'd0, a_i[31:0]};
        rem_r  <= '0;
        b_r    <= b_i;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (last) begin
          busy_r <= 1'b0;
        end
        if (div_r) begin
          rem_r <= ge ? (rem_sh - {1'b0, b_r}) : rem_sh;
          acc_r <= {acc_r[62:0], ge};
        end else begin
          acc_r <= {mul_sum, acc_r[31:1]};
        end
      end
    end
  end

  assign done_o = done_r;
  assign res_o  = acc_r;

endmodule

[hdl/mlfqs_fixed_point_scheduler_math.sv]
// Top level of the fixed-point scheduler math block (load average, recent CPU, priority).
//
//   channel  direction  ports
//   in       input      in_valid/in_ready, func, thread_index, ready_count, ...
//   out      output     out_valid/out_ready, priority_res, recent_cpu_x100, load_avg_x100
//
// One item at a time runs through a bit-serial multiply/divide unit, one bit per cycle.
// Decay and load update run more serial multiplies and divides than clear, tick, set nice
// and priority, which run only the output multiplies.
// Reset is synchronous; a new item is taken while a finished result still waits.
// A stalled output holds the finished item, and the next one waits before its transfer.
module mlfqs_fixed_point_scheduler_math #(
  parameter int THREADS       = mlfqs_pkg::THREADS_DEF,
  parameter int PRIORITY_MAX  = mlfqs_pkg::PRIORITY_MAX_DEF,
  parameter int FRACTION_BITS = mlfqs_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [5:0]         in_thread_index,
  input  logic [6:0]         in_ready_count,
  input  logic               in_running_is_idle,
  input  logic signed [5:0]  in_new_nice,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         out_priority_res,
  output logic signed [31:0] out_recent_cpu_x100,
  output logic [12:0]        out_load_avg_x100
);

  import mlfqs_pkg::*;

  localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam logic [63:0] ONE  = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_OP, S_L1, S_L2, S_L3, S_D1, S_D2, S_D3,
    S_WB, S_O1, S_O2, S_PR, S_DONE
  } state_t;

  state_t             state_r;
  logic [2:0]         func_r;
  logic [IW-1:0]      idx_r;
  logic [6:0]         rdy_r;
  logic               idle_r;
  logic signed [5:0]  newnice_r;
  logic signed [31:0] rc_r;
  logic signed [5:0]  nv_r;
  logic [31:0]        load_r;
  logic [31:0]        p1_r;
  logic [31:0]        rcx_r;
  logic [12:0]        la_r;
  logic [5:0]         pri_r;
  logic [THREADS-1:0] valid_r;
  logic               out_valid_r;
  logic [5:0]         out_pri_r;
  logic [31:0]        out_rcx_r;
  logic [12:0]        out_la_r;
  unit_ctl_t          ctl_r;
  logic [63:0]        ua_r;
  logic [31:0]        ub_r;

  logic               u_done;
  logic [63:0]        u_res;
  logic [IW-1:0]      mod_tab [64];
  logic [IW-1:0]      rd_idx;
  logic [31:0]        rc_ram_q;
  logic [5:0]         nv_ram_q;
  logic               wr_en;

  logic [31:0]        rc_mag;
  logic [31:0]        tick_val;
  logic [31:0]        p_sat;
  logic [7:0]         rdy_tot;
  logic [31:0]        load_sum;
  logic [32:0]        d_wide;
  logic [31:0]        d_val;
  logic [32:0]        den_wide;
  logic [31:0]        den_val;
  logic [63:0]        pm;
  logic signed [47:0] ps;
  logic [31:0]        rc_nice;
  logic [63:0]        rq;
  logic [31:0]        rcx_val;
  logic [63:0]        lq;
  logic [12:0]        la_val;
  logic signed [39:0] q4;
  logic signed [39:0] px;
  logic [39:0]        pr_q;
  logic [5:0]         pri_val;

  genvar k;
  generate
    for (k = 0; k < 64; k++) begin : g_mod
      assign mod_tab[k] = IW'(k % THREADS);
    end
  endgenerate

  assign rd_idx = mod_tab[in_thread_index];
  assign wr_en  = (state_r == S_WB);

  mlfqs_ram #(.WIDTH(TABLE_W), .DEPTH(THREADS)) u_rc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata (rc_r),
    .raddr (rd_idx),
    .rdata (rc_ram_q)
  );

  mlfqs_ram #(.WIDTH(NICE_W), .DEPTH(THREADS)) u_nice_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_r),
    .wdata (nv_r),
    .raddr (rd_idx),
    .rdata (nv_ram_q)
  );

  mlfqs_serial_unit u_unit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_r),
    .a_i    (ua_r),
    .b_i    (ub_r),
    .done_o (u_done),
    .res_o  (u_res)
  );

  always_comb begin
    rc_mag   = rc_r[31] ? (~rc_r + 32'd1) : rc_r;
    tick_val = sat32(48'(rc_r) + 48'(ONE));
    p_sat    = (u_res > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : u_res[31:0];
    rdy_tot  = {1'b0, rdy_r} + {7'd0, !idle_r};
    load_sum = sat32({16'd0, p1_r} + {16'd0, u_res[31:0]});
    d_wide   = {load_r, 1'b0};
    d_val    = (d_wide > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : d_wide[31:0];
    den_wide = {1'b0, d_val} + ONE[32:0];
    den_val  = (den_wide > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : den_wide[31:0];
    pm       = u_res >> FRACTION_BITS;
    ps       = rc_r[31] ? -$signed(pm[47:0]) : $signed(pm[47:0]);
    rc_nice  = sat32(48'(rc_r) + (48'(nv_r) <<< FRACTION_BITS));
    rq       = (u_res + HALF) >> FRACTION_BITS;
    rcx_val  = rc_r[31] ? (~rq[31:0] + 32'd1) : rq[31:0];
    lq       = (u_res + HALF) >> FRACTION_BITS;
    la_val   = (lq > 64'(LOAD_OUT_MAX)) ? 13'(LOAD_OUT_MAX) : lq[12:0];
    q4       = rc_r[31] ? ((40'(rc_r) + 40'sd3) >>> 2) : (40'(rc_r) >>> 2);
    px       = (40'(PRIORITY_MAX) <<< FRACTION_BITS) - q4
               - (40'(nv_r) <<< (FRACTION_BITS + 1));
    pr_q     = 40'(px + 40'(HALF)) >> FRACTION_BITS;
    if (px < 0) begin
      pri_val = 6'd0;
    end else if (pr_q > 40'(PRIORITY_MAX)) begin
      pri_val = 6'(PRIORITY_MAX);
    end else begin
      pri_val = pr_q[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      ctl_r       <= '0;
    end else begin
      if (ctl_r.start) begin
        ctl_r <= '0;
      end
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            func_r    <= in_func;
            idx_r     <= rd_idx;
            rdy_r     <= in_ready_count;
            idle_r    <= in_running_is_idle;
            newnice_r <= in_new_nice;
            state_r   <= S_RD;
          end
        end
        S_RD: begin
          rc_r    <= valid_r[idx_r] ? rc_ram_q : 32'd0;
          nv_r    <= valid_r[idx_r] ? nv_ram_q : 6'd0;
          state_r <= S_OP;
        end
        S_OP: begin
          state_r <= S_WB;
          case (func_r)
            FUNC_CLEAR: begin
              rc_r <= '0;
              nv_r <= '0;
            end
            FUNC_TICK: begin
              if (!idle_r) begin
                rc_r <= tick_val;
              end
            end
            FUNC_LOAD: begin
              ctl_r   <= '{start: 1'b1, is_div: 1'b0};
              ua_r    <= {32'd0, load_r};
              ub_r    <= 32'd59;
              state_r <= S_L1;
            end
            FUNC_DECAY: begin
              ctl_r   <= '{start: 1'b1, is_div: 1'b1};
              ua_r    <= {32'd0, d_val} << FRACTION_BITS;
              ub_r    <= den_val;
              state_r <= S_D1;
            end
            FUNC_SET_NICE: begin
              nv_r <= newnice_r;
            end
            default: begin
            end
          endcase
        end
        S_L1: begin
          if (u_done) begin
            ctl_r   <= '{start: 1'b1, is_div: 1'b1};
            ua_r    <= {32'd0, p_sat};
            ub_r    <= 32'd60;
            state_r <= S_L2;
          end
        end
        S_L2: begin
          if (u_done) begin
            p1_r    <= u_res[31:0];
            ctl_r   <= '{start: 1'b1, is_div: 1'b1};
            ua_r    <= {56'd0, rdy_tot} << FRACTION_BITS;
            ub_r    <= 32'd60;
            state_r <= S_L3;
          end
        end
        S_L3: begin
          if (u_done) begin
            load_r  <= load_sum;
            state_r <= S_WB;
          end
        end
        S_D1: begin
          if (u_done) begin
            ctl_r   <= '{start: 1'b1, is_div: 1'b0};
            ua_r    <= {32'd0, u_res[31:0]};
            ub_r    <= rc_mag;
            state_r <= S_D2;
          end
        end
        S_D2: begin
          if (u_done) begin
            rc_r    <= sat32(ps);
            state_r <= S_D3;
          end
        end
        S_D3: begin
          rc_r    <= rc_nice;
          state_r <= S_WB;
        end
        S_WB: begin
          valid_r[idx_r] <= 1'b1;
          ctl_r   <= '{start: 1'b1, is_div: 1'b0};
          ua_r    <= {32'd0, rc_mag};
          ub_r    <= 32'd100;
          state_r <= S_O1;
        end
        S_O1: begin
          if (u_done) begin
            rcx_r   <= rcx_val;
            ctl_r   <= '{start: 1'b1, is_div: 1'b0};
            ua_r    <= {32'd0, load_r};
            ub_r    <= 32'd100;
            state_r <= S_O2;
          end
        end
        S_O2: begin
          if (u_done) begin
            la_r    <= la_val;
            state_r <= S_PR;
          end
        end
        S_PR: begin
          pri_r   <= pri_val;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pri_r   <= pri_r;
            out_rcx_r   <= rcx_r;
            out_la_r    <= la_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_priority_res    = out_pri_r;
  assign out_recent_cpu_x100 = out_rcx_r;
  assign out_load_avg_x100   = out_la_r;

endmodule

[hdl/mlfqs_chk.sv]
// Port-level checker for the scheduler math block, bound to the top level.
module mlfqs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [12:0] out_load_avg_x100
);

  import mlfqs_pkg::*;

  logic [2:0] cnt_r;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + {2'd0, in_xfer} - {2'd0, out_xfer};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result withdrawn before its transfer.");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> cnt_r != 3'd0)
    else $error("Result transfer without a pending input transfer.");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd2)
    else $error("More than two items in flight.");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_load_avg_x100 <= 13'(LOAD_OUT_MAX))
    else $error("Load average output beyond its limit.");

endmodule

bind mlfqs_fixed_point_scheduler_math mlfqs_chk u_mlfqs_chk (.*);

[bench/tb_mlfqs_fixed_point_scheduler_math.sv]
// Self-checking testbench of the fixed-point scheduler math block with a scoreboard class.
`timescale 1ns / 100ps

class sched_scoreboard;
  int load_fp;
  int recent_fp[64];
  int nice_val[64];
  int fail_count;
  logic [5:0] exp_pri_q[$];
  logic [31:0] exp_rc_q[$];
  logic [12:0] exp_la_q[$];

  function new();
    load_fp = 0;
    fail_count = 0;
    foreach (recent_fp[i]) begin
      recent_fp[i] = 0;
      nice_val[i] = 0;
    end
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function longint round14(longint x);
    if (x >= 0) return (x + 8192) / 16384;
    return (x - 8192) / 16384;
  endfunction

  function void note_input(logic [2:0] func, logic [5:0] idx, logic [6:0] rdy,
                           logic idle, logic signed [5:0] nv);
    longint ready, p1, p2, d, den, c, prod, rc, la, pr;
    ready = rdy;
    case (func)
      mlfqs_pkg::FUNC_CLEAR: begin
        recent_fp[idx] = 0;
        nice_val[idx] = 0;
      end
      mlfqs_pkg::FUNC_TICK: begin
        if (!idle) recent_fp[idx] = clamp32(longint'(recent_fp[idx]) + 16384);
      end
      mlfqs_pkg::FUNC_LOAD: begin
        if (!idle) ready += 1;
        p1 = clamp32(longint'(load_fp) * 59) / 60;
        p2 = clamp32(ready * 16384) / 60;
        load_fp = clamp32(p1 + p2);
      end
      mlfqs_pkg::FUNC_DECAY: begin
        d = clamp32(longint'(load_fp) * 2);
        den = clamp32(d + 16384);
        if (den <= 0) den = 1;
        c = clamp32((d * 16384) / den);
        prod = clamp32((c * longint'(recent_fp[idx])) / 16384);
        recent_fp[idx] = clamp32(prod + longint'(nice_val[idx]) * 16384);
      end
      mlfqs_pkg::FUNC_SET_NICE: nice_val[idx] = nv;
      default: ;
    endcase
    rc = clamp32(round14(longint'(recent_fp[idx]) * 100));
    la = round14(longint'(load_fp) * 100);
    if (la < 0) la = 0;
    if (la > 8191) la = 8191;
    pr = round14(63 * 16384 - longint'(recent_fp[idx]) / 4
                 - longint'(nice_val[idx]) * 32768);
    if (pr < 0) pr = 0;
    if (pr > 63) pr = 63;
    exp_pri_q.push_back(pr[5:0]);
    exp_rc_q.push_back(rc[31:0]);
    exp_la_q.push_back(la[12:0]);
  endfunction

  function void check_result(logic [5:0] pri, logic [31:0] rc, logic [12:0] la);
    logic [5:0] e_pri;
    logic [31:0] e_rc;
    logic [12:0] e_la;
    if (exp_pri_q.size() == 0) begin
      $error("result transfer with no expected result");
      fail_count++;
      return;
    end
    e_pri = exp_pri_q.pop_front();
    e_rc = exp_rc_q.pop_front();
    e_la = exp_la_q.pop_front();
    if (pri !== e_pri) begin
      $error("priority_res expected %0d actual %0d", e_pri, pri);
      fail_count++;
    end
    if (rc !== e_rc) begin
      $error("recent_cpu_x100 expected %0d actual %0d", $signed(e_rc), $signed(rc));
      fail_count++;
    end
    if (la !== e_la) begin
      $error("load_avg_x100 expected %0d actual %0d", e_la, la);
      fail_count++;
    end
  endfunction
endclass

module tb_mlfqs_fixed_point_scheduler_math;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_func = '0;
  logic [5:0] in_thread_index = '0;
  logic [6:0] in_ready_count = '0;
  logic in_running_is_idle = 1'b0;
  logic signed [5:0] in_new_nice = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_priority_res;
  logic signed [31:0] out_recent_cpu_x100;
  logic [12:0] out_load_avg_x100;

  sched_scoreboard sb;
  int cycle_count = 0;
  bit quiet_phase = 0;
  bit stim_done = 0;

  always #10 clk = ~clk;

  mlfqs_fixed_point_scheduler_math u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_func(in_func), .in_thread_index(in_thread_index),
    .in_ready_count(in_ready_count), .in_running_is_idle(in_running_is_idle),
    .in_new_nice(in_new_nice),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_priority_res(out_priority_res), .out_recent_cpu_x100(out_recent_cpu_x100),
    .out_load_avg_x100(out_load_avg_x100)
  );

  task automatic send_item(logic [2:0] f, logic [5:0] idx, logic [6:0] rdy,
                           logic idle, logic signed [5:0] nv);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_thread_index <= idx;
    in_ready_count <= rdy;
    in_running_is_idle <= idle;
    in_new_nice <= nv;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, idx, rdy, idle, nv);
  endtask

  task automatic send_random(int hot_threads);
    logic [2:0] f;
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) f = mlfqs_pkg::FUNC_TICK;
    else if (r < 45) f = mlfqs_pkg::FUNC_LOAD;
    else if (r < 60) f = mlfqs_pkg::FUNC_DECAY;
    else if (r < 72) f = mlfqs_pkg::FUNC_SET_NICE;
    else if (r < 84) f = mlfqs_pkg::FUNC_PRIORITY;
    else if (r < 92) f = mlfqs_pkg::FUNC_CLEAR;
    else f = 3'($urandom_range(6, 7));
    send_item(f, 6'($urandom_range(0, hot_threads)), 7'($urandom),
              ($urandom_range(0, 4) == 0), 6'($urandom));
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_item(mlfqs_pkg::FUNC_PRIORITY, 6'd0, 7'd0, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_SET_NICE, 6'd63, 7'd0, 1'b0, -6'sd20);
    send_item(mlfqs_pkg::FUNC_SET_NICE, 6'd1, 7'd0, 1'b0, 6'sd20);
    send_item(mlfqs_pkg::FUNC_SET_NICE, 6'd2, 7'd0, 1'b0, 6'sh20);
    send_item(mlfqs_pkg::FUNC_SET_NICE, 6'd3, 7'd0, 1'b0, 6'sd31);
    send_item(mlfqs_pkg::FUNC_TICK, 6'd63, 7'd0, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_TICK, 6'd63, 7'd0, 1'b1, 6'sd0);
    send_item(mlfqs_pkg::FUNC_LOAD, 6'd0, 7'd127, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_LOAD, 6'd0, 7'd64, 1'b1, 6'sd0);
    send_item(mlfqs_pkg::FUNC_LOAD, 6'd0, 7'd0, 1'b1, 6'sd0);
    send_item(mlfqs_pkg::FUNC_DECAY, 6'd63, 7'd0, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_DECAY, 6'd1, 7'd0, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_DECAY, 6'd2, 7'd0, 1'b0, 6'sd0);
    send_item(3'd6, 6'd1, 7'd5, 1'b1, 6'sd7);
    send_item(3'd7, 6'd2, 7'd9, 1'b0, -6'sd7);
    send_item(mlfqs_pkg::FUNC_CLEAR, 6'd1, 7'd0, 1'b0, 6'sd0);
    send_item(mlfqs_pkg::FUNC_PRIORITY, 6'd1, 7'd0, 1'b0, 6'sd0);
    for (int i = 0; i < 30; i++) send_item(mlfqs_pkg::FUNC_LOAD, 6'd0, 7'd127, 1'b0, 6'sd0);
    for (int i = 0; i < 1500; i++) begin
      if (i == 1300) quiet_phase = 1;
      if (i % 300 < 200) send_random(3);
      else send_random(63);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready)
      sb.check_result(out_priority_res, out_recent_cpu_x100, out_load_avg_x100);
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.exp_pri_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.fail_count == 0 && sb.exp_pri_q.size() == 0) begin
      $display("tb_mlfqs_fixed_point_scheduler_math OK");
    end else begin
      $display("tb_mlfqs_fixed_point_scheduler_math NOT OK");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("tb_mlfqs_fixed_point_scheduler_math NOT OK");
      $finish;
    end
  end
endmodule

[mlfqs_fixed_point_scheduler_math.f]
hdl/mlfqs_pkg.sv
hdl/mlfqs_ram.sv
hdl/mlfqs_serial_unit.sv
hdl/mlfqs_fixed_point_scheduler_math.sv
hdl/mlfqs_chk.sv
bench/tb_mlfqs_fixed_point_scheduler_math.sv
